// ===== hdl/tsfd_pkg.sv =====
// Shared types and constants for the turn signal flasher with debounce.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tsfd_pkg;

   localparam int TIME_W  = 32;
   localparam int SPEED_W = 16;
   localparam int CSR_W   = 16;

   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

   // Register reset values
   localparam logic [CSR_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CSR_W-1:0] BLINK_RESET    = 16'd500;
   localparam logic [CSR_W-1:0] STEP_RESET     = 16'd100;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_UNRESTRICTED = 2'd0,
      CSR_DEBOUNCE     = 2'd1,
      CSR_BLINK        = 2'd2,
      CSR_STEP         = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             unrestricted_mode;
      logic [CSR_W-1:0] debounce_ms;
      logic [CSR_W-1:0] blink_interval_ms;
      logic [CSR_W-1:0] speed_step_rpm;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic               left_level;
      logic               right_level;
      logic [SPEED_W-1:0] speed_limit_in;
      logic [SPEED_W-1:0] taper_start_in;
   } req_type;

   typedef struct packed {
      logic               left_lamp;
      logic               right_lamp;
      logic [SPEED_W-1:0] speed_limit_out;
      logic [SPEED_W-1:0] taper_start_out;
   } rsp_type;

   typedef struct packed {
      logic left;
      logic right;
   } press_type;

endpackage

`default_nettype wire

// ===== hdl/tsfd_csr.sv =====
// Configuration registers of the flasher, written over the csr_ channel.
// Depends on tsfd_pkg.
`default_nettype none

module tsfd_csr
   import tsfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [CSR_W-1:0] csr_data,
   output cfg_type            cfg
);

   cfg_type cfg_ff;

   // Accept a transfer in every cycle
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Hold the registers; update the addressed one on a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unrestricted_mode <= 1'b0;
         cfg_ff.debounce_ms       <= DEBOUNCE_RESET;
         cfg_ff.blink_interval_ms <= BLINK_RESET;
         cfg_ff.speed_step_rpm    <= STEP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_UNRESTRICTED: cfg_ff.unrestricted_mode <= csr_data[0];
            CSR_DEBOUNCE:     cfg_ff.debounce_ms       <= csr_data;
            CSR_BLINK:        cfg_ff.blink_interval_ms <= csr_data;
            CSR_STEP:         cfg_ff.speed_step_rpm    <= csr_data;
            default:          cfg_ff                   <= cfg_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tsfd_debounce.sv =====
// Debouncer for one active-low button: stable level, time of last change.
// Flags a press edge once a change has waited the debounce time. Uses tsfd_pkg.
`default_nettype none

module tsfd_debounce
   import tsfd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              raw_level,
   input  wire logic [TIME_W-1:0] now_ms,
   input  wire logic [CSR_W-1:0]  debounce_ms,
   output logic                   press
);

   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              raw_pressed;
   logic [TIME_W-1:0] elapsed;
   logic              accept_change;

   assign raw_pressed   = ~raw_level;
   assign elapsed       = now_ms - change_time_ff;
   assign accept_change = (raw_pressed != stable_ff) &&
                          (elapsed >= {{(TIME_W-CSR_W){1'b0}}, debounce_ms});

   // Take the new level once it has settled; report a release-to-press edge
   always_comb begin
      stable_in      = stable_ff;
      change_time_in = change_time_ff;
      if (accept_change) begin
         stable_in      = raw_pressed;
         change_time_in = now_ms;
      end
   end

   assign press = accept_change & raw_pressed;

   // Hold the debouncer state; advance it once per processed poll
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b0;
         change_time_ff <= '0;
      end else if (advance) begin
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tsfd_ctrl.sv =====
// Blinker enables, blink phase, speed adjustment and lamp drive.
// Depends on tsfd_pkg; fed by the two tsfd_debounce instances.
`default_nettype none

module tsfd_ctrl
   import tsfd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire cfg_type   cfg,
   input  wire press_type press,
   input  wire req_type   req,
   output rsp_type        result
);

   logic              left_enabled_ff, left_enabled_in;
   logic              right_enabled_ff, right_enabled_in;
   logic              phase_ff, phase_in;
   logic [TIME_W-1:0] phase_time_ff, phase_time_in;
   logic [TIME_W-1:0] phase_elapsed;
   logic [SPEED_W-1:0] limit_dec;
   logic [SPEED_W-1:0] taper_dec;
   logic [SPEED_W:0]   limit_sum;
   logic [SPEED_W-1:0] limit_out;
   logic [SPEED_W-1:0] taper_out;

   // Toggle enables in normal mode: left first, then right
   always_comb begin
      left_enabled_in  = left_enabled_ff;
      right_enabled_in = right_enabled_ff;
      if (!cfg.unrestricted_mode) begin
         if (press.left) begin
            left_enabled_in  = ~left_enabled_in;
            right_enabled_in = 1'b0;
         end
         if (press.right) begin
            right_enabled_in = ~right_enabled_in;
            left_enabled_in  = 1'b0;
         end
      end
   end

   // On a left press in unrestricted mode, lower the limit (floor at zero) and pull the taper down to it
   always_comb begin
      limit_dec = req.speed_limit_in;
      taper_dec = req.taper_start_in;
      if (cfg.unrestricted_mode && press.left) begin
         limit_dec = (req.speed_limit_in > cfg.speed_step_rpm) ?
                     req.speed_limit_in - cfg.speed_step_rpm : '0;
         if (req.taper_start_in > limit_dec) begin
            taper_dec = limit_dec;
         end
      end
   end

   // On a right press in unrestricted mode, raise the limit, saturating at full scale
   assign limit_sum = {1'b0, limit_dec} + {1'b0, cfg.speed_step_rpm};

   always_comb begin
      limit_out = limit_dec;
      taper_out = taper_dec;
      if (cfg.unrestricted_mode && press.right) begin
         limit_out = limit_sum[SPEED_W] ? SPEED_MAX : limit_sum[SPEED_W-1:0];
      end
   end

   // Flip the blink phase once the interval has gone by
   assign phase_elapsed = req.now_ms - phase_time_ff;

   always_comb begin
      phase_in      = phase_ff;
      phase_time_in = phase_time_ff;
      if (phase_elapsed >= {{(TIME_W-CSR_W){1'b0}}, cfg.blink_interval_ms}) begin
         phase_in      = ~phase_ff;
         phase_time_in = req.now_ms;
      end
   end

   // Drive the lamps from the updated enables and phase, dark when unrestricted
   always_comb begin
      result.left_lamp       = ~cfg.unrestricted_mode & left_enabled_in & phase_in;
      result.right_lamp      = ~cfg.unrestricted_mode & right_enabled_in & phase_in;
      result.speed_limit_out = limit_out;
      result.taper_start_out = taper_out;
   end

   // Hold enables and phase; advance once per processed poll
   always_ff @(posedge clock) begin
      if (reset) begin
         left_enabled_ff  <= 1'b0;
         right_enabled_ff <= 1'b0;
         phase_ff         <= 1'b0;
         phase_time_ff    <= '0;
      end else if (advance) begin
         left_enabled_ff  <= left_enabled_in;
         right_enabled_ff <= right_enabled_in;
         phase_ff         <= phase_in;
         phase_time_ff    <= phase_time_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/turn_signal_flasher_with_debounce_top.sv =====
// A poll is registered from req_, then its result is registered and offered on rsp_.
// Throughput: one poll per cycle while rsp_stall is low; input and result registers
// form two stages; an empty input stage takes a poll while a result waits on rsp_stall.
// Reset (synchronous, active high) empties both stages, clears debouncers,
// enables and blink phase, and loads the register defaults 0/50/500/100.
// Top level: input register, tsfd_debounce x2, tsfd_ctrl, tsfd_csr, result register.
`default_nettype none

module turn_signal_flasher_with_debounce_top
   import tsfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_payload,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [CSR_W-1:0] csr_data
);

   cfg_type   cfg;
   req_type   req_ff;
   logic      req_valid_ff;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   rsp_type   result;
   press_type press;
   logic      left_press;
   logic      right_press;
   logic      out_free;
   logic      advance;

   // The result register frees up when empty or when its transfer completes
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = req_valid_ff & out_free;
   assign req_stall = req_valid_ff & ~out_free;

   tsfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tsfd_debounce u_left_debounce (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .raw_level   (req_ff.left_level),
      .now_ms      (req_ff.now_ms),
      .debounce_ms (cfg.debounce_ms),
      .press       (left_press)
   );

   tsfd_debounce u_right_debounce (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .raw_level   (req_ff.right_level),
      .now_ms      (req_ff.now_ms),
      .debounce_ms (cfg.debounce_ms),
      .press       (right_press)
   );

   // Gather both press edges for the controller
   assign press = {left_press, right_press};

   tsfd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .press   (press),
      .req     (req_ff),
      .result  (result)
   );

   // Input stage: take a poll whenever the stage is empty or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_payload;
      end
   end

   // Result stage: load on advance, drop on a completed transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
